>>> hdl/cau_pkg.sv
// Package: shared types, codes and saturation helpers for the complex ALU.
`timescale 1ns / 1ps
package cau_pkg;

    localparam int FRAC_BITS_DEF = 8;
    // Quotient bits kept by the divider chain; anything larger saturates.
    localparam int QUOT_BITS = 17;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_NEG = 3'd4
    } action_t;

    typedef struct packed {
        logic [2:0]          action;
        logic signed [15:0]  a_re;
        logic signed [15:0]  a_im;
        logic signed [15:0]  b_re;
        logic signed [15:0]  b_im;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0]  res_re;
        logic signed [15:0]  res_im;
        logic                overflow;
        logic                div_zero;
    } out_word_t;

    // Per-item control riding alongside the divider chain.
    typedef struct packed {
        logic                is_div;
        logic                dz;
        logic                neg_re;
        logic                neg_im;
        logic                big_re;
        logic                big_im;
        logic signed [15:0]  res_re;
        logic signed [15:0]  res_im;
        logic                ovf;
    } side_t;

    function automatic logic signed [15:0] sat_val(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd32767)
            r = 16'sh7fff;
        else if (v < -34'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic logic sat_ovf(input logic signed [33:0] v);
        return (v > 34'sd32767) || (v < -34'sd32768);
    endfunction

endpackage

>>> hdl/cau_stream_if.sv
// Interface: valid/ready word channel with a typed payload.
`timescale 1ns / 1ps
interface cau_stream_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/complex_arith_unit.sv
// Top level: pipelined complex ALU on signed fixed-point operands.
`timescale 1ns / 1ps
// Usage
//   in_ch carries one word per item: action plus complex operands A and B.
//   out_ch carries one result word per item: res_re, res_im, overflow,
//   div_zero. Both channels use valid/ready; a word moves when both are high.
// Pipeline and throughput
//   Every action takes the same path: 3 front stages (products, sums,
//   divider setup), QUOT_BITS (17) divider cells, then the output register.
//   One word is accepted every cycle unless the output stalls; the rate is
//   set by the cell chain, which retires one quotient bit per cell per cycle
//   for both parts at once.
// Reset
//   rst_n clears all valid bits; the pipeline comes up empty and ready.
// Stall
//   When the output word is held (valid high, ready low) the whole pipeline
//   freezes and in_ch.ready drops; nothing is lost or duplicated. While the
//   output register is empty or being taken, in_ch.ready stays high.
// Division
//   Magnitude quotients use restoring division on (2|n|*2^F + d) / (2d),
//   which gives round-to-nearest with ties away from zero. Quotients that
//   need more than QUOT_BITS bits are flagged up front and saturate.
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    cau_stream_if.sink   in_ch,
    cau_stream_if.source out_ch
);

    localparam int XW  = 34 + FRAC_BITS;           // dividend width
    localparam int DW  = 33;                       // 2*d width
    localparam int CW  = DW + QUOT_BITS + 1;       // compare width in cells
    localparam logic signed [33:0] RND =
        (FRAC_BITS == 0) ? 34'sd0 : 34'sd1 <<< (FRAC_BITS - 1);

    logic en;

    // stage 1: operands and products
    logic               v1_reg;
    logic [2:0]         act1_reg;
    logic signed [15:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [31:0] prr1_reg, pii1_reg, pri1_reg, pir1_reg, pbb1_reg, pqq1_reg;

    // stage 2: sums and non-divide results
    logic               v2_reg;
    side_t              side2_reg, side2_next;
    logic signed [33:0] nre2_reg, nim2_reg;
    logic [31:0]        d2_reg;

    // stage 3: divider setup
    logic               v3_reg;
    side_t              side3_reg, side3_next;
    logic [XW-1:0]      xre3_reg, xim3_reg, xre3_next, xim3_next;
    logic [DW-1:0]      den3_reg;

    // output
    logic               out_valid_reg;
    out_word_t          out_word_reg, out_word_next;

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act1_reg <= in_ch.data.action;
            ar1_reg  <= in_ch.data.a_re;
            ai1_reg  <= in_ch.data.a_im;
            br1_reg  <= in_ch.data.b_re;
            bi1_reg  <= in_ch.data.b_im;
            prr1_reg <= in_ch.data.a_re * in_ch.data.b_re;
            pii1_reg <= in_ch.data.a_im * in_ch.data.b_im;
            pri1_reg <= in_ch.data.a_re * in_ch.data.b_im;
            pir1_reg <= in_ch.data.a_im * in_ch.data.b_re;
            pbb1_reg <= in_ch.data.b_re * in_ch.data.b_re;
            pqq1_reg <= in_ch.data.b_im * in_ch.data.b_im;
        end
    end

    // stage 2 logic
    logic signed [33:0] s2_re, s2_im, m_re, m_im;
    logic [31:0]        d2_next;

    always_comb
    begin
        s2_re   = 34'sd0;
        s2_im   = 34'sd0;
        m_re    = (34'(prr1_reg) - 34'(pii1_reg) + RND) >>> FRAC_BITS;
        m_im    = (34'(pri1_reg) + 34'(pir1_reg) + RND) >>> FRAC_BITS;
        d2_next = 32'(pbb1_reg) + 32'(pqq1_reg);
        side2_next = '0;
        unique case (act1_reg)
            ACT_ADD:
            begin
                s2_re = 34'(ar1_reg) + 34'(br1_reg);
                s2_im = 34'(ai1_reg) + 34'(bi1_reg);
            end
            ACT_SUB:
            begin
                s2_re = 34'(ar1_reg) - 34'(br1_reg);
                s2_im = 34'(ai1_reg) - 34'(bi1_reg);
            end
            ACT_MUL:
            begin
                s2_re = m_re;
                s2_im = m_im;
            end
            ACT_DIV:
            begin
                side2_next.is_div = 1'b1;
                side2_next.dz     = (d2_next == 32'd0);
            end
            ACT_NEG:
            begin
                s2_re = -34'(ar1_reg);
                s2_im = -34'(ai1_reg);
            end
            default:
            begin
                s2_re = 34'sd0;
                s2_im = 34'sd0;
            end
        endcase
        side2_next.res_re = sat_val(s2_re);
        side2_next.res_im = sat_val(s2_im);
        side2_next.ovf    = sat_ovf(s2_re) || sat_ovf(s2_im);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side2_reg <= side2_next;
            nre2_reg  <= 34'(prr1_reg) + 34'(pii1_reg);
            nim2_reg  <= 34'(pir1_reg) - 34'(pri1_reg);
            d2_reg    <= d2_next;
        end
    end

    // stage 3 logic: magnitudes, scaled dividends, early saturation check
    logic [32:0]   mag_re, mag_im;
    logic [DW-1:0] den3_next;

    always_comb
    begin
        mag_re    = nre2_reg[33] ? 33'(-nre2_reg) : 33'(nre2_reg);
        mag_im    = nim2_reg[33] ? 33'(-nim2_reg) : 33'(nim2_reg);
        xre3_next = (XW'(mag_re) << (FRAC_BITS + 1)) + XW'(d2_reg);
        xim3_next = (XW'(mag_im) << (FRAC_BITS + 1)) + XW'(d2_reg);
        den3_next = {d2_reg, 1'b0};
        side3_next        = side2_reg;
        side3_next.neg_re = nre2_reg[33];
        side3_next.neg_im = nim2_reg[33];
        side3_next.big_re = CW'(xre3_next) >= (CW'(den3_next) << QUOT_BITS);
        side3_next.big_im = CW'(xim3_next) >= (CW'(den3_next) << QUOT_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg <= side3_next;
            xre3_reg  <= xre3_next;
            xim3_reg  <= xim3_next;
            den3_reg  <= den3_next;
        end
    end

    // divider cell chain, most significant quotient bit first
    logic                 cv   [0:QUOT_BITS];
    logic [XW-1:0]        crre [0:QUOT_BITS];
    logic [XW-1:0]        crim [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] cqre [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] cqim [0:QUOT_BITS];
    logic [DW-1:0]        cden [0:QUOT_BITS];
    side_t                cside[0:QUOT_BITS];

    assign cv[0]    = v3_reg;
    assign crre[0]  = xre3_reg;
    assign crim[0]  = xim3_reg;
    assign cqre[0]  = '0;
    assign cqim[0]  = '0;
    assign cden[0]  = den3_reg;
    assign cside[0] = side3_reg;

    genvar k;
    generate
        for (k = 0; k < QUOT_BITS; k++)
        begin : g_cell
            cau_div_cell #(
                .XW  (XW),
                .DW  (DW),
                .CW  (CW),
                .BIT (QUOT_BITS - 1 - k)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .valid_in   (cv[k]),
                .rem_re_in  (crre[k]),
                .rem_im_in  (crim[k]),
                .q_re_in    (cqre[k]),
                .q_im_in    (cqim[k]),
                .den_in     (cden[k]),
                .side_in    (cside[k]),
                .valid_out  (cv[k+1]),
                .rem_re_out (crre[k+1]),
                .rem_im_out (crim[k+1]),
                .q_re_out   (cqre[k+1]),
                .q_im_out   (cqim[k+1]),
                .den_out    (cden[k+1]),
                .side_out   (cside[k+1])
            );
        end
    endgenerate

    // final: sign, saturate, select
    function automatic logic [16:0] div_part(input logic [QUOT_BITS-1:0] q,
                                             input logic neg, input logic big);
        logic        ovf;
        logic [15:0] val;
        if (neg)
            ovf = big || (q > QUOT_BITS'(32768));
        else
            ovf = big || (q > QUOT_BITS'(32767));
        if (ovf)
            val = neg ? 16'h8000 : 16'h7fff;
        else
            val = neg ? 16'(-q) : q[15:0];
        return {ovf, val};
    endfunction

    side_t       fs;
    logic [16:0] fre, fim;

    always_comb
    begin
        fs  = cside[QUOT_BITS];
        fre = div_part(cqre[QUOT_BITS], fs.neg_re, fs.big_re);
        fim = div_part(cqim[QUOT_BITS], fs.neg_im, fs.big_im);
        out_word_next = '0;
        if (fs.is_div)
        begin
            if (fs.dz)
                out_word_next.div_zero = 1'b1;
            else
            begin
                out_word_next.res_re   = fre[15:0];
                out_word_next.res_im   = fim[15:0];
                out_word_next.overflow = fre[16] || fim[16];
            end
        end
        else
        begin
            out_word_next.res_re   = fs.res_re;
            out_word_next.res_im   = fs.res_im;
            out_word_next.overflow = fs.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= cv[QUOT_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_word_reg <= out_word_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_word_reg;

endmodule

>>> hdl/cau_div_cell.sv
// Divider cell: one restoring-division quotient bit for both result parts.
`timescale 1ns / 1ps
module cau_div_cell
    import cau_pkg::*;
#(
    parameter int XW  = 42,
    parameter int DW  = 33,
    parameter int CW  = 51,
    parameter int BIT = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic [XW-1:0]        rem_re_in,
    input  logic [XW-1:0]        rem_im_in,
    input  logic [QUOT_BITS-1:0] q_re_in,
    input  logic [QUOT_BITS-1:0] q_im_in,
    input  logic [DW-1:0]        den_in,
    input  side_t                side_in,
    output logic                 valid_out,
    output logic [XW-1:0]        rem_re_out,
    output logic [XW-1:0]        rem_im_out,
    output logic [QUOT_BITS-1:0] q_re_out,
    output logic [QUOT_BITS-1:0] q_im_out,
    output logic [DW-1:0]        den_out,
    output side_t                side_out
);

    logic [CW-1:0]        sub_ext;
    logic [CW-1:0]        re_ext;
    logic [CW-1:0]        im_ext;
    logic [CW-1:0]        re_diff;
    logic [CW-1:0]        im_diff;
    logic                 re_take;
    logic                 im_take;
    logic [XW-1:0]        rem_re_next;
    logic [XW-1:0]        rem_im_next;
    logic [QUOT_BITS-1:0] q_re_next;
    logic [QUOT_BITS-1:0] q_im_next;
    logic                 valid_reg;
    logic [XW-1:0]        rem_re_reg;
    logic [XW-1:0]        rem_im_reg;
    logic [QUOT_BITS-1:0] q_re_reg;
    logic [QUOT_BITS-1:0] q_im_reg;
    logic [DW-1:0]        den_reg;
    side_t                side_reg;

    always_comb
    begin
        sub_ext = CW'(den_in) << BIT;
        re_ext  = CW'(rem_re_in);
        im_ext  = CW'(rem_im_in);
        re_diff = re_ext - sub_ext;
        im_diff = im_ext - sub_ext;
        re_take = re_ext >= sub_ext;
        im_take = im_ext >= sub_ext;
        rem_re_next = re_take ? re_diff[XW-1:0] : rem_re_in;
        rem_im_next = im_take ? im_diff[XW-1:0] : rem_im_in;
        q_re_next = q_re_in;
        q_im_next = q_im_in;
        q_re_next[BIT] = re_take;
        q_im_next[BIT] = im_take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_re_reg <= rem_re_next;
            rem_im_reg <= rem_im_next;
            q_re_reg   <= q_re_next;
            q_im_reg   <= q_im_next;
            den_reg    <= den_in;
            side_reg   <= side_in;
        end
    end

    assign valid_out  = valid_reg;
    assign rem_re_out = rem_re_reg;
    assign rem_im_out = rem_im_reg;
    assign q_re_out   = q_re_reg;
    assign q_im_out   = q_im_reg;
    assign den_out    = den_reg;
    assign side_out   = side_reg;

endmodule

>>> bench/testbench.sv
// Testbench for complex_arith_unit: directed and random words, predicted and checked.
`timescale 1ns / 1ps
module testbench
    import cau_pkg::*;
();

    // Clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    cau_stream_if #(.word_t(in_word_t))  in_ch();
    cau_stream_if #(.word_t(out_word_t)) out_ch();

    complex_arith_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    localparam int FB       = FRAC_BITS_DEF;
    localparam int LATENCY  = 21;
    localparam int N_RANDOM = 1525;
    localparam longint CYCLE_LIMIT = 200000;

    in_word_t  pending_words[$];   // filled by the stimulus block, drained by the driver
    out_word_t expected_results[$];
    int        error_count = 0;
    int        results_seen = 0;
    int        div_zero_seen = 0;
    int        overflow_seen = 0;
    bit        stimulus_done = 1'b0;
    bit        quiet_phase = 1'b0;  // no idling near the end of the run
    bit        hold_sender = 1'b0;  // sender paused until the pipeline drains
    longint    cycle_count = 0;

    // Round-half-up scale down by FB bits; arithmetic shift is a floor.
    function automatic longint scale_round(input longint x);
        return (x + (longint'(1) << (FB - 1))) >>> FB;
    endfunction

    // Rounded quotient, ties away from zero; d > 0.
    function automatic longint div_round(input longint n, input longint d);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (2 * mag + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v, inout logic ovf);
        if (v > 32767)
        begin
            ovf = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            ovf = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Expected result word for one operand word.
    function automatic out_word_t complex_result(input in_word_t w);
        out_word_t r;
        longint ar, ai, br, bi, rr, ri, mag2;
        logic ovf;
        ar = w.a_re;
        ai = w.a_im;
        br = w.b_re;
        bi = w.b_im;
        rr = 0;
        ri = 0;
        ovf = 1'b0;
        r.div_zero = 1'b0;
        case (w.action)
            ACT_ADD:
            begin
                rr = ar + br;
                ri = ai + bi;
            end
            ACT_SUB:
            begin
                rr = ar - br;
                ri = ai - bi;
            end
            ACT_MUL:
            begin
                rr = scale_round(ar * br - ai * bi);
                ri = scale_round(ar * bi + ai * br);
            end
            ACT_DIV:
            begin
                mag2 = br * br + bi * bi;
                if (mag2 == 0)
                    r.div_zero = 1'b1;
                else
                begin
                    rr = div_round((ar * br + ai * bi) <<< FB, mag2);
                    ri = div_round((ai * br - ar * bi) <<< FB, mag2);
                end
            end
            ACT_NEG:
            begin
                rr = -ar;
                ri = -ai;
            end
            default: ;
        endcase
        r.res_re = clamp16(rr, ovf);
        r.res_im = clamp16(ri, ovf);
        r.overflow = ovf;
        return r;
    endfunction

    function automatic in_word_t make_word(input logic [2:0] act, input int ar, input int ai,
                                           input int br, input int bi);
        in_word_t w;
        w.action = act;
        w.a_re = ar[15:0];
        w.a_im = ai[15:0];
        w.b_re = br[15:0];
        w.b_im = bi[15:0];
        return w;
    endfunction

    // Operand mix: full range, small values, extremes, tiny divisors.
    function automatic logic [15:0] rand_part();
        case ($urandom_range(0, 5))
            0, 1: return 16'($urandom());
            2:    return 16'($signed($urandom_range(0, 1023)) - 512);
            3:    return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            4:    return 16'($signed($urandom_range(0, 6)) - 3);
            default: return 16'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    initial
    begin
        logic [2:0] act;
        pending_words.push_back(make_word(ACT_ADD, 32767, 32767, 32767, 32767));
        pending_words.push_back(make_word(ACT_ADD, -32768, -32768, -32768, -32768));
        pending_words.push_back(make_word(ACT_ADD, 256, -256, 512, 128));
        pending_words.push_back(make_word(ACT_SUB, -32768, 32767, 32767, -32768));
        pending_words.push_back(make_word(ACT_SUB, 1000, -1000, 1000, -1000));
        pending_words.push_back(make_word(ACT_MUL, -32768, -32768, -32768, -32768));
        pending_words.push_back(make_word(ACT_MUL, 32767, 0, 32767, 0));
        pending_words.push_back(make_word(ACT_MUL, 384, 128, -256, 1));    // rounding ties
        pending_words.push_back(make_word(ACT_MUL, 1, 0, 128, 0));
        pending_words.push_back(make_word(ACT_MUL, -1, 0, 128, 0));
        pending_words.push_back(make_word(ACT_DIV, 256, 256, 0, 0));       // zero divisor
        pending_words.push_back(make_word(ACT_DIV, -32768, -32768, 0, 0));
        pending_words.push_back(make_word(ACT_DIV, 32767, -32768, 1, 0));  // huge quotient
        pending_words.push_back(make_word(ACT_DIV, -32768, 32767, 0, -1));
        pending_words.push_back(make_word(ACT_DIV, 256, 0, 512, 0));
        pending_words.push_back(make_word(ACT_DIV, 1, 0, 512, 0));         // half tie
        pending_words.push_back(make_word(ACT_DIV, -1, 0, 512, 0));
        pending_words.push_back(make_word(ACT_DIV, 32767, 32767, -32768, -32768));
        pending_words.push_back(make_word(ACT_NEG, -32768, -32768, 5, 5)); // negate overflow
        pending_words.push_back(make_word(ACT_NEG, 32767, 1, -1, 0));
        pending_words.push_back(make_word(3'd5, 100, 100, 100, 100));     // unused selectors
        pending_words.push_back(make_word(3'd6, -1, -1, -1, -1));
        pending_words.push_back(make_word(3'd7, 32767, -32768, 0, 0));
        @(posedge clk);
        wait (pending_words.size() == 0);
        // Pause the sender until every directed result is back.
        hold_sender = 1'b1;
        wait (expected_results.size() == 0);
        hold_sender = 1'b0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            act = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            pending_words.push_back(make_word(act, $signed(rand_part()), $signed(rand_part()),
                                              $signed(rand_part()), $signed(rand_part())));
            if (n == N_RANDOM - 200)
                quiet_phase = 1'b1;
            if (pending_words.size() > 8)
                wait (pending_words.size() <= 8);
        end
        wait (pending_words.size() == 0);
        stimulus_done = 1'b1;
    end

    // Driver: one word per handshake, random idle bursts.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_results.push_back(complex_result(in_ch.data));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_words.size() > 0 && !hold_sender)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_words.pop_front();
                    if (!quiet_phase && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 4);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result word with the oldest prediction.
    int stall_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result word with no prediction waiting: %h", out_ch.data);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.div_zero)
                        div_zero_seen++;
                    if (want.overflow)
                        overflow_seen++;
                    if (out_ch.data.res_re !== want.res_re)
                    begin
                        $error("res_re expected %0d got %0d", want.res_re, out_ch.data.res_re);
                        error_count++;
                    end
                    if (out_ch.data.res_im !== want.res_im)
                    begin
                        $error("res_im expected %0d got %0d", want.res_im, out_ch.data.res_im);
                        error_count++;
                    end
                    if (out_ch.data.overflow !== want.overflow)
                    begin
                        $error("overflow expected %0b got %0b", want.overflow,
                               out_ch.data.overflow);
                        error_count++;
                    end
                    if (out_ch.data.div_zero !== want.div_zero)
                    begin
                        $error("div_zero expected %0b got %0b", want.div_zero,
                               out_ch.data.div_zero);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 3);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (stimulus_done);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("checked %0d result words: %0d overflowed, %0d divided by zero",
                 results_seen, overflow_seen, div_zero_seen);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
